@@ rtl/c2d_pkg.sv @@
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared constants and types for the streaming 3x3 convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int SAMPLE_BITS = 16;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WREG_W     = COL_W + 1;
	localparam int ROW_W      = 12;
	localparam int COEF_BITS  = 16;
	localparam int COEF_ROW_W = 3 * COEF_BITS;
	localparam int OUT_W      = 36;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int RSUM_W = PROD_W + 2;
	localparam int SUM_W  = PROD_W + 4;
	localparam int ACC_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;

	// line memory entry: row-2 sample in the upper half, row-1 in the lower
	localparam int ENTRY_W = 2 * SAMPLE_BITS;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF2  = 3'd4;

	localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(5);
	localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(5);

	typedef logic [SAMPLE_BITS-1:0] smp_t;
	typedef smp_t [8:0] win_t;              // [r*3+c], r=0 oldest row, c=0 oldest col
	typedef logic [2:0][COEF_ROW_W-1:0] coef_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} tag_t;

endpackage

`default_nettype wire

@@ rtl/c2d_line_buf.sv @@
// ----------------------------------------------------------------------------
// c2d_line_buf
// Two line buffers packed in one synchronous memory, one read and one write
// per cycle, with forwarding of a same-cycle write to the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_line_buf (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rd_en,
	input  wire logic [c2d_pkg::COL_W-1:0]   rd_addr,
	input  wire logic                        wr_en,
	input  wire logic [c2d_pkg::COL_W-1:0]   wr_addr,
	input  wire logic [c2d_pkg::ENTRY_W-1:0] wr_data,
	output logic      [c2d_pkg::ENTRY_W-1:0] rd_data
);
	import c2d_pkg::*;

	logic [ENTRY_W-1:0] mem [MAX_WIDTH];
	logic [ENTRY_W-1:0] ram_q;
	logic [ENTRY_W-1:0] fwd_data_q;
	logic               fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q      <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// read data is held until the next read, even across stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : ram_q;

endmodule

`default_nettype wire

@@ rtl/c2d_mac.sv @@
// ----------------------------------------------------------------------------
// c2d_mac
// Nine parallel products, row sums, final sum and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_mac (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire c2d_pkg::win_t                    win,
	input  wire c2d_pkg::coef_t                   coef,
	input  wire c2d_pkg::tag_t                    tag,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [c2d_pkg::OUT_W-1:0]      out_value,
	output c2d_pkg::tag_t                         out_tag
);
	import c2d_pkg::*;

	logic signed [PROD_W-1:0] prod_c  [9];
	logic signed [PROD_W-1:0] prod_s2 [9];
	logic signed [RSUM_W-1:0] rsum_c  [3];
	logic signed [RSUM_W-1:0] rsum_s3 [3];
	logic        [ACC_W-1:0]  acc_c;
	tag_t                     tag_s2, tag_s3;
	logic                     valid_s2, valid_s3, valid_q;
	logic                     ready_s2, ready_s3, ready_o;
	logic [OUT_W-1:0]         value_q;
	tag_t                     tag_q;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_c[r*3+c] = $signed(win[r*3+c]) *
					$signed(coef[r][c*COEF_BITS +: COEF_BITS]);
			end
		end
		for (int r = 0; r < 3; r++) begin
			rsum_c[r] = RSUM_W'(prod_s2[r*3]) + RSUM_W'(prod_s2[r*3+1])
				+ RSUM_W'(prod_s2[r*3+2]);
		end
		acc_c = ACC_W'(rsum_s3[0]) + ACC_W'(rsum_s3[1]) + ACC_W'(rsum_s3[2]);
	end

	assign ready_o  = !valid_q || out_ready;
	assign ready_s3 = !valid_s3 || ready_o;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_o) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			prod_s2 <= prod_c;
			tag_s2  <= tag;
		end
		if (ready_s3 && valid_s2) begin
			rsum_s3 <= rsum_c;
			tag_s3  <= tag_s2;
		end
		if (ready_o && valid_s3) begin
			value_q <= acc_c[OUT_W-1:0];
			tag_q   <= tag_s3;
		end
	end

	assign out_valid = valid_q;
	assign out_value = $signed(value_q);
	assign out_tag   = tag_q;

endmodule

`default_nettype wire

@@ rtl/conv2d_3x3_valid_stream.sv @@
// ----------------------------------------------------------------------------
// conv2d_3x3_valid_stream
// Streaming 3x3 valid cross-correlation over raster-order samples.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// pixel     pix_valid/pix_ready    sample, frame_start
// result    res_valid/res_ready    conv_value, out_row, out_col, last
// config    cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// One sample per cycle unless the result path stalls; the line memory does one
// read and one write per accepted sample. A result passes through the memory read,
// products, row sums and output register stages after its sample is accepted.
// No clearing pass after reset: line memory contents are undefined until written.
// Each stage holds while the next is full and stalled, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_3x3_valid_stream (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pix_valid,
	output logic                                     pix_ready,
	input  wire logic signed [c2d_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic                                frame_start,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic signed [c2d_pkg::OUT_W-1:0]         conv_value,
	output logic        [c2d_pkg::ROW_W-1:0]         out_row,
	output logic        [c2d_pkg::COL_W-1:0]         out_col,
	output logic                                     last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic   [c2d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic   [c2d_pkg::COEF_ROW_W-1:0]    cfg_data
);
	import c2d_pkg::*;

	logic [WREG_W-1:0] width_q;
	logic [ROW_W-1:0]  height_q;
	coef_t             coef_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic [WREG_W-1:0] eff_w;
	logic [ROW_W-1:0]  eff_h, hm1;
	logic [COL_W-1:0]  wm1, col_base, col0;
	logic [ROW_W-1:0]  row_base, row0;
	logic              end_col, end_row, emit, pix_fire;

	logic              s1_valid, s1_emit, s1_fire;
	smp_t              s1_sample;
	logic [COL_W-1:0]  s1_col;
	tag_t              s1_tag;

	logic [ENTRY_W-1:0] lb_rd;
	smp_t              up1, up2;
	win_t              win_q, win_c;
	logic              mac_ready;
	tag_t              res_tag;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			coef_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH:  width_q   <= cfg_data[WREG_W-1:0];
				CFG_HEIGHT: height_q  <= cfg_data[ROW_W-1:0];
				CFG_COEF0:  coef_q[0] <= cfg_data;
				CFG_COEF1:  coef_q[1] <= cfg_data;
				CFG_COEF2:  coef_q[2] <= cfg_data;
				default:    ;
			endcase
		end
	end

	// ---------------- position counters ----------------
	always_comb begin
		if (width_q < WREG_W'(3)) begin
			eff_w = WREG_W'(3);
		end else if (width_q > WREG_W'(MAX_WIDTH)) begin
			eff_w = WREG_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q < ROW_W'(3)) ? ROW_W'(3) : height_q;
		wm1   = COL_W'(eff_w - WREG_W'(1));
		hm1   = eff_h - ROW_W'(1);

		col_base = frame_start ? '0 : col_q;
		row_base = frame_start ? '0 : row_q;
		col0 = ({1'b0, col_base} >= eff_w) ? '0 : col_base;
		row0 = (row_base >= eff_h) ? '0 : row_base;

		end_col = col0 >= wm1;
		end_row = row0 >= hm1;
		emit    = (row0 >= ROW_W'(2)) && (col0 >= COL_W'(2));
	end

	assign pix_fire = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= end_row ? '0 : row0 + ROW_W'(1);
			end else begin
				col_q <= col0 + COL_W'(1);
				row_q <= row0;
			end
		end
	end

	// ---------------- stage 1: line memory read, window update ----------------
	assign s1_fire   = s1_valid && (!s1_emit || mac_ready);
	assign pix_ready = !s1_valid || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (pix_ready) begin
			s1_valid <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			s1_sample   <= sample;
			s1_col      <= col0;
			s1_emit     <= emit;
			s1_tag.row  <= row0 - ROW_W'(2);
			s1_tag.col  <= col0 - COL_W'(2);
			s1_tag.last <= end_row && end_col;
		end
	end

	c2d_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (pix_fire),
		.rd_addr (col0),
		.wr_en   (s1_fire),
		.wr_addr (s1_col),
		.wr_data ({up1, s1_sample}),
		.rd_data (lb_rd)
	);

	assign up1 = lb_rd[SAMPLE_BITS-1:0];
	assign up2 = lb_rd[ENTRY_W-1:SAMPLE_BITS];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_c[r*3]   = win_q[r*3+1];
			win_c[r*3+1] = win_q[r*3+2];
		end
		win_c[2] = up2;
		win_c[5] = up1;
		win_c[8] = s1_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_fire) begin
			win_q <= win_c;
		end
	end

	// ---------------- products, sums, output register ----------------
	c2d_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid && s1_emit),
		.in_ready  (mac_ready),
		.win       (win_c),
		.coef      (coef_q),
		.tag       (s1_tag),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_value (conv_value),
		.out_tag   (res_tag)
	);

	assign out_row = res_tag.row;
	assign out_col = res_tag.col;
	assign last    = res_tag.last;

endmodule

`default_nettype wire
